// ===== hdl/kws_pkg.sv =====
// Shared types, constants and helper functions for the keyword substitution cipher.
package kws_pkg;

  localparam int LETTERS = 26;
  localparam int IDX_W   = 5;

  localparam logic [7:0] ASCII_UPPER_A = 8'h41;
  localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
  localparam logic [7:0] ASCII_LOWER_A = 8'h61;
  localparam logic [7:0] ASCII_LOWER_Z = 8'h7A;
  localparam logic [IDX_W-1:0] LAST_LETTER = IDX_W'(LETTERS - 1);
  localparam logic [IDX_W:0]   FULL_COUNT  = (IDX_W+1)'(LETTERS);

  typedef enum logic [1:0] {
    CMD_KEY     = 2'd0,
    CMD_FINISH  = 2'd1,
    CMD_ENCRYPT = 2'd2,
    CMD_DECRYPT = 2'd3
  } cmd_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic key_char;
    logic fill_init;
    logic fill_step;
    logic encrypt;
    logic decrypt;
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic keyword_open;
    logic fill_last;
  } stat_t;

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= ASCII_UPPER_A) && (c <= ASCII_UPPER_Z)) ||
           ((c >= ASCII_LOWER_A) && (c <= ASCII_LOWER_Z));
  endfunction

  // Letter index 0..25; zero for a non-letter.
  function automatic logic [IDX_W-1:0] letter_index(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if ((c >= ASCII_UPPER_A) && (c <= ASCII_UPPER_Z)) begin
      d = c - ASCII_UPPER_A;
    end else if ((c >= ASCII_LOWER_A) && (c <= ASCII_LOWER_Z)) begin
      d = c - ASCII_LOWER_A;
    end
    return d[IDX_W-1:0];
  endfunction

endpackage

// ===== hdl/kws_ctrl.sv =====
// Controller state machine: decodes requests and sequences the finish fill.
module kws_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [1:0]    command,
  input  kws_pkg::stat_t stat,
  output kws_pkg::ctrl_t ctrl,
  output logic          busy
);
  import kws_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_FILL = 2'b10
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign accept = start && (state == ST_IDLE);
  assign busy   = (state == ST_FILL);

  always_comb begin
    state_next = state;
    ctrl       = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (cmd_t'(command))
            CMD_KEY:     ctrl.key_char = 1'b1;
            CMD_FINISH: begin
              if (stat.keyword_open) begin
                ctrl.fill_init = 1'b1;
                state_next     = ST_FILL;
              end
            end
            CMD_ENCRYPT: ctrl.encrypt = 1'b1;
            CMD_DECRYPT: ctrl.decrypt = 1'b1;
            default:     ctrl = '0;
          endcase
        end
      end
      ST_FILL: begin
        ctrl.fill_step = 1'b1;
        if (stat.fill_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hdl/kws_datapath.sv =====
// Datapath: cipher tables, keyword bookkeeping, fill walker and result register.
module kws_datapath (
  input  logic           clk,
  input  logic           rst,
  input  logic [7:0]     char_in,
  input  kws_pkg::ctrl_t ctrl,
  output kws_pkg::stat_t stat,
  output logic           done,
  output logic [6:0]     char_out
);
  import kws_pkg::*;

  logic [IDX_W-1:0] fwd [LETTERS];
  logic [IDX_W-1:0] inv [LETTERS];
  logic [LETTERS-1:0] used;
  logic [IDX_W:0]     klen;
  logic               kopen;
  logic [IDX_W-1:0]   fill_letter;
  logic [IDX_W:0]     fill_pos;

  logic               letter;
  logic [IDX_W-1:0]   idx;
  logic [LETTERS-1:0] used_eff;
  logic [IDX_W:0]     klen_eff;
  logic               key_new;
  logic               fill_new;
  logic               fwd_we, inv_we;
  logic [IDX_W-1:0]   fwd_addr, fwd_data, inv_addr, inv_data;
  logic [IDX_W-1:0]   table_val;

  assign letter = is_letter(char_in);
  assign idx    = letter_index(char_in);

  // A keyword character that opens a new keyword sees an empty history.
  assign used_eff = kopen ? used : '0;
  assign klen_eff = kopen ? klen : '0;
  assign key_new  = ctrl.key_char && letter && !used_eff[idx] && (klen_eff < FULL_COUNT);
  assign fill_new = ctrl.fill_step && !used[fill_letter] && (fill_pos < FULL_COUNT);

  always_comb begin
    fwd_we   = key_new || fill_new;
    inv_we   = fwd_we;
    if (key_new) begin
      fwd_addr = klen_eff[IDX_W-1:0];
      fwd_data = idx;
      inv_addr = idx;
      inv_data = klen_eff[IDX_W-1:0];
    end else begin
      fwd_addr = fill_pos[IDX_W-1:0];
      fwd_data = fill_letter;
      inv_addr = fill_letter;
      inv_data = fill_pos[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    for (int e = 0; e < LETTERS; e++) begin
      if (rst) begin
        fwd[e] <= IDX_W'(e);
        inv[e] <= IDX_W'(e);
      end else begin
        if (fwd_we && (fwd_addr == IDX_W'(e))) fwd[e] <= fwd_data;
        if (inv_we && (inv_addr == IDX_W'(e))) inv[e] <= inv_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used  <= '0;
      klen  <= '0;
      kopen <= 1'b0;
    end else if (ctrl.key_char) begin
      kopen <= 1'b1;
      if (key_new) begin
        used <= used_eff | (LETTERS'(1) << idx);
        klen <= klen_eff + 1'b1;
      end else begin
        used <= used_eff;
        klen <= klen_eff;
      end
    end else if (ctrl.fill_step && stat.fill_last) begin
      kopen <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.fill_init) begin
      fill_letter <= '0;
      fill_pos    <= klen;
    end else if (ctrl.fill_step) begin
      fill_letter <= fill_letter + 1'b1;
      if (fill_new) fill_pos <= fill_pos + 1'b1;
    end
  end

  assign stat.keyword_open = kopen;
  assign stat.fill_last    = (fill_letter == LAST_LETTER);

  assign table_val = ctrl.encrypt ? fwd[idx] : inv[idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (ctrl.encrypt || ctrl.decrypt) && letter;
    end
    char_out <= ASCII_LOWER_A[6:0] + {2'b00, table_val};
  end

endmodule

// ===== hdl/keyword_substitution_cipher_core.sv =====
// Top level of the keyword substitution cipher: controller plus datapath.
// Result: an encrypt or decrypt request of a letter gives its result in the next cycle.
// Throughput: keyword and text requests are taken every cycle while not busy; a finish
// of an open keyword holds busy while the fill walker visits one letter per cycle.
// Reset (synchronous, rst high) restores identity tables and closes the keyword.
// The receiver cannot stall: done marks a result for exactly one cycle.
module keyword_substitution_cipher_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] command,
  input  logic [7:0] char_in,
  output logic       done,
  output logic [6:0] char_out
);
  import kws_pkg::*;

  // Command and status groups between the two halves.
  ctrl_t ctrl;
  stat_t stat;

  // The controller accepts a request when start is high and it is not busy.
  // Only a finish request with an open keyword leaves the idle state.
  kws_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .stat    (stat),
    .ctrl    (ctrl),
    .busy    (busy)
  );

  // The datapath holds both tables and registers each text result.
  kws_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .char_in  (char_in),
    .ctrl     (ctrl),
    .stat     (stat),
    .done     (done),
    .char_out (char_out)
  );

  // A result only follows an accepted encrypt or decrypt request.
  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy &&
                   (command == CMD_ENCRYPT || command == CMD_DECRYPT)))
    else $error("result without a text request");

  // Results are always lowercase letters.
  a_out_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (char_out >= 7'd97 && char_out <= 7'd122))
    else $error("result outside the lowercase letters");

  // Busy only starts from an accepted finish request.
  a_busy_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start && command == CMD_FINISH))
    else $error("busy without a finish request");

  // No result is produced during the fill walk.
  a_no_done_fill: assert property (@(posedge clk) disable iff (rst)
    (busy && $past(busy)) |-> !done)
    else $error("result during fill");

endmodule

// ===== verif/tb_keyword_substitution_cipher_core.sv =====
// Self-checking testbench for the keyword substitution cipher core.
`timescale 1ns / 1ps

module tb_keyword_substitution_cipher_core;
  import kws_pkg::*;

  // One request as the driver presents it to the block.
  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] ch;
  } kws_req_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic [1:0] command = CMD_KEY;
  logic [7:0] char_in = 8'h00;
  logic       busy;
  logic       done;
  logic [6:0] char_out;

  keyword_substitution_cipher_core u_top (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .command  (command),
    .char_in  (char_in),
    .done     (done),
    .char_out (char_out)
  );

  // 20 ns clock period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Requests waiting to be driven, and the cipher letters the block still owes us.
  kws_req_t   req_q[$];
  logic [6:0] pending_chars[$];

  // Our own copy of the cipher state: substitution tables, letters already in
  // the keyword, how many keyword letters are placed, and whether a keyword
  // is being entered.
  logic [4:0]  fwd_map[LETTERS];
  logic [4:0]  inv_map[LETTERS];
  logic [25:0] used_mask;
  logic [5:0]  key_len;
  logic        key_open;

  int          err_count = 0;
  int          result_count = 0;
  logic        took = 1'b0;
  int unsigned idle_left = 0;
  int unsigned calm_left = 0;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  // Append one request to the stimulus queue.
  task automatic add_req(input cmd_t cmd, input logic [7:0] ch);
    kws_req_t r;
    r.cmd = cmd;
    r.ch  = ch;
    req_q.push_back(r);
  endtask

  // A letter given by its index, in upper or lower case at random.
  function automatic logic [7:0] letter_byte(input int idx);
    logic [7:0] base;
    base = ($urandom_range(0, 1) != 0) ? ASCII_UPPER_A : ASCII_LOWER_A;
    return base + 8'(idx);
  endfunction

  // Apply one accepted request to the cipher state and queue the letter it
  // should produce, if any. Folding bit 5 high maps both cases of a letter
  // onto the lowercase range, and no other byte lands there.
  task automatic predict_cipher_char(input cmd_t cmd, input logic [7:0] ch);
    logic [7:0] folded;
    logic       is_alpha;
    logic [4:0] idx;
    logic [5:0] pos;
    int         i;
    folded   = ch | 8'h20;
    is_alpha = (folded >= ASCII_LOWER_A) && (folded <= ASCII_LOWER_Z);
    idx      = 5'(folded - ASCII_LOWER_A);
    case (cmd)
      CMD_KEY: begin
        // The first keyword request after a finish starts a fresh keyword,
        // even when the character itself is not a letter.
        if (!key_open) begin
          used_mask = '0;
          key_len   = '0;
          key_open  = 1'b1;
        end
        // Repeated letters are dropped; a new one takes the next position.
        if (is_alpha && !used_mask[idx] && key_len < LETTERS) begin
          used_mask[idx]  = 1'b1;
          fwd_map[key_len] = idx;
          inv_map[idx]     = 5'(key_len);
          key_len++;
        end
      end
      CMD_FINISH: begin
        // Only an open keyword is finished: the unused letters fill the
        // remaining positions in alphabetical order. A finish while closed
        // leaves everything as it is.
        if (key_open) begin
          pos = key_len;
          for (i = 0; i < LETTERS; i++) begin
            if (!used_mask[i] && pos < LETTERS) begin
              fwd_map[pos] = 5'(i);
              inv_map[i]   = 5'(pos);
              pos++;
            end
          end
          key_open = 1'b0;
        end
      end
      CMD_ENCRYPT: begin
        if (is_alpha) pending_chars.push_back(7'(ASCII_LOWER_A + fwd_map[idx]));
      end
      default: begin
        if (is_alpha) pending_chars.push_back(7'(ASCII_LOWER_A + inv_map[idx]));
      end
    endcase
  endtask

  // Driver: inputs change on the falling edge. A request stays up until the
  // block takes it, then the line idles for the number of cycles drawn when
  // that request was put up. Now and then a calm stretch with no idling runs.
  always @(negedge clk) begin
    kws_req_t nxt;
    if (!rst && (!start || took)) begin
      if (idle_left != 0) begin
        idle_left <= idle_left - 1;
        start     <= 1'b0;
      end else if (req_q.size() != 0) begin
        nxt      = req_q.pop_front();
        start    <= 1'b1;
        command  <= nxt.cmd;
        char_in  <= nxt.ch;
        if (calm_left != 0) begin
          calm_left <= calm_left - 1;
        end else begin
          idle_left <= $urandom_range(0, 7);
          if ($urandom_range(0, 15) == 0) calm_left <= $urandom_range(10, 40);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: everything is sampled on the rising edge. A result is checked
  // against the oldest owed letter; a request taken at this edge updates the
  // predicted state. Results appear in the cycle after their request, so the
  // order of the two steps here does not matter.
  always @(posedge clk) begin
    logic [6:0] want;
    if (rst) begin
      took <= 1'b0;
    end else begin
      if ($isunknown(done)) begin
        report_mismatch("done is unknown");
      end else if (done) begin
        result_count++;
        if (pending_chars.size() == 0) begin
          report_mismatch($sformatf("unexpected result 0x%02h", char_out));
        end else begin
          want = pending_chars.pop_front();
          if (char_out !== want)
            report_mismatch($sformatf("result %0d: char_out 0x%02h, wanted 0x%02h",
                                      result_count, char_out, want));
        end
      end
      if (start && !busy) predict_cipher_char(cmd_t'(command), char_in);
      took <= start && !busy;
    end
  end

  // Stimulus, reset and the end of the run.
  initial begin
    logic [4:0] perm[LETTERS];
    logic [4:0] tmp;
    int         i, j, klen, tlen, roll;

    for (i = 0; i < LETTERS; i++) begin
      fwd_map[i] = 5'(i);
      inv_map[i] = 5'(i);
    end
    used_mask = '0;
    key_len   = '0;
    key_open  = 1'b0;

    // Directed part. Identity tables first, with the letter range edges and
    // the bytes just outside both letter ranges.
    add_req(CMD_ENCRYPT, "a");
    add_req(CMD_DECRYPT, "Z");
    add_req(CMD_ENCRYPT, 8'h40);
    add_req(CMD_DECRYPT, 8'h5B);
    add_req(CMD_ENCRYPT, 8'h60);
    add_req(CMD_DECRYPT, 8'h7B);
    add_req(CMD_ENCRYPT, 8'hFF);
    add_req(CMD_DECRYPT, 8'h00);
    // Finish with no keyword open must leave the tables alone.
    add_req(CMD_FINISH, 8'hA5);
    add_req(CMD_ENCRYPT, "m");
    // A non-letter opens the keyword; the lowercase z repeats the capital Z.
    add_req(CMD_KEY, "7");
    add_req(CMD_KEY, "Z");
    add_req(CMD_KEY, "e");
    add_req(CMD_KEY, "z");
    add_req(CMD_KEY, "B");
    // Text while the keyword is still open sees partly rewritten tables.
    add_req(CMD_ENCRYPT, "z");
    add_req(CMD_DECRYPT, "a");
    add_req(CMD_KEY, "R");
    add_req(CMD_FINISH, 8'h00);
    add_req(CMD_ENCRYPT, "A");
    add_req(CMD_ENCRYPT, "z");
    add_req(CMD_DECRYPT, "q");
    add_req(CMD_FINISH, 8'hFF);
    add_req(CMD_DECRYPT, "Y");

    // Random part. Most of it is whole sessions: a keyword, a finish and a
    // run of text. Keywords are mostly short; now and then one is a full
    // shuffled alphabet. The rest is noise on any command with any byte.
    while (req_q.size() < 1000) begin
      roll = $urandom_range(0, 99);
      if (roll < 80) begin
        if ($urandom_range(0, 9) == 0) begin
          klen = LETTERS;
          for (i = 0; i < LETTERS; i++) perm[i] = 5'(i);
          for (i = LETTERS - 1; i > 0; i--) begin
            j       = $urandom_range(0, i);
            tmp     = perm[i];
            perm[i] = perm[j];
            perm[j] = tmp;
          end
        end else begin
          klen = $urandom_range(0, 8);
          for (i = 0; i < klen; i++) perm[i] = 5'($urandom_range(0, LETTERS - 1));
        end
        for (i = 0; i < klen; i++) begin
          if ($urandom_range(0, 9) == 0) add_req(CMD_KEY, 8'($urandom_range(0, 255)));
          add_req(CMD_KEY, letter_byte(perm[i]));
        end
        // Occasionally the finish is left out so that text meets an open keyword.
        if ($urandom_range(0, 9) != 0) add_req(CMD_FINISH, 8'($urandom_range(0, 255)));
        tlen = $urandom_range(1, 12);
        for (i = 0; i < tlen; i++) begin
          if ($urandom_range(0, 7) == 0)
            add_req($urandom_range(0, 1) ? CMD_ENCRYPT : CMD_DECRYPT,
                    8'($urandom_range(0, 255)));
          else
            add_req($urandom_range(0, 1) ? CMD_ENCRYPT : CMD_DECRYPT,
                    letter_byte($urandom_range(0, LETTERS - 1)));
        end
      end else begin
        tlen = $urandom_range(1, 5);
        for (i = 0; i < tlen; i++)
          add_req(cmd_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end
    end

    // Reset is held high from the start and released on a falling edge.
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Wait until every request is taken and every owed letter has come, then
    // allow for a finish fill still in progress.
    while (req_q.size() != 0 || start) @(posedge clk);
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
